[design/mbde_pkg.sv]
package mbde_pkg;

	localparam int NUM_INPUTS_DEF = 32;
	localparam int MASK_W         = 32;
	localparam int TIME_W         = 32;
	localparam int DEBOUNCE_W     = 16;
	localparam int BIT_IDX_W      = 5;
	localparam int CFG_IDX_W      = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_MASK = 2'd0,
		REG_DEBOUNCE   = 2'd1,
		REG_POLARITY   = 2'd2
	} cfg_reg_t;

	// what one lane reports for the current sample
	typedef struct packed {
		logic hit;
		logic rising;
		logic is_active;
	} lane_evt_t;

endpackage

[design/mbde_sample_if.sv]
interface mbde_sample_if import mbde_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] sample;
	logic [TIME_W-1:0] now_ms;

	modport source(output valid, output sample, output now_ms, input ready);
	modport sink(input valid, input sample, input now_ms, output ready);
endinterface

[design/mbde_event_if.sv]
interface mbde_event_if import mbde_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [BIT_IDX_W-1:0] bit_index;
	logic                 rising;
	logic                 is_active;
	logic [TIME_W-1:0]    stamp_ms;
	logic                 last;

	modport source(output valid, output bit_index, output rising, output is_active,
		output stamp_ms, output last, input ready);
	modport sink(input valid, input bit_index, input rising, input is_active,
		input stamp_ms, input last, output ready);
endinterface

[design/mbde_lane.sv]
module mbde_lane import mbde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  monitored,
	input  logic                  low_true,
	input  logic [DEBOUNCE_W-1:0] debounce_ms,
	input  logic                  cur,
	input  logic [TIME_W-1:0]     now_ms,
	output lane_evt_t             evt
);

	logic              stable_q;
	logic              open_q;
	logic [TIME_W-1:0] start_q;
	logic              prev_q;
	logic              agree_q;

	logic              busy;
	logic              close;
	logic [TIME_W-1:0] start_eff;
	logic              agree_eff;
	logic [TIME_W-1:0] elapsed;

	always_comb begin
		busy      = monitored && (open_q || (cur != stable_q));
		start_eff = open_q ? start_q : now_ms;
		agree_eff = open_q ? (agree_q && (cur == prev_q)) : 1'b1;
		// wraps modulo 2^32
		elapsed   = now_ms - start_eff;
		close     = busy && (elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms});
		evt.hit       = close && agree_eff && (cur != stable_q);
		evt.rising    = cur;
		evt.is_active = (cur != low_true);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			open_q   <= 1'b0;
		end else if (accept && busy) begin
			if (close) begin
				open_q   <= 1'b0;
				stable_q <= cur;
			end else begin
				open_q <= 1'b1;
			end
		end
	end

	// window payload is only read while open_q is set
	always_ff @(posedge clk) begin
		if (accept && busy && !close) begin
			start_q <= start_eff;
			agree_q <= agree_eff;
			prev_q  <= cur;
		end
	end

endmodule

[design/mbde_merge.sv]
module mbde_merge import mbde_pkg::*; #(
	parameter int NUM_INPUTS = NUM_INPUTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  lane_evt_t            lane_evt [NUM_INPUTS],
	input  logic [TIME_W-1:0]    now_ms,
	output logic                 take_ok,
	mbde_event_if.source         evt
);

	logic [NUM_INPUTS-1:0] mask_q;
	logic [NUM_INPUTS-1:0] level_q;
	logic [NUM_INPUTS-1:0] act_q;
	logic [TIME_W-1:0]     stamp_q;

	logic                  out_valid_q;
	logic [BIT_IDX_W-1:0]  out_idx_q;
	logic                  out_rising_q;
	logic                  out_active_q;
	logic [TIME_W-1:0]     out_stamp_q;
	logic                  out_last_q;

	logic [NUM_INPUTS-1:0] lowest;
	logic [NUM_INPUTS-1:0] rest;
	logic [BIT_IDX_W-1:0]  low_idx;
	logic                  out_free;
	logic                  pop;

	always_comb begin
		lowest   = mask_q & (~mask_q + 1'b1);
		rest     = mask_q & ~lowest;
		low_idx  = '0;
		for (int i = NUM_INPUTS - 1; i >= 0; i--) begin
			if (mask_q[i]) low_idx = BIT_IDX_W'(i);
		end
		out_free = !out_valid_q || evt.ready;
		pop      = (mask_q != '0) && out_free;
		// batch frees up once its last beat moves to the output register
		take_ok  = (mask_q == '0) || (pop && (rest == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				for (int i = 0; i < NUM_INPUTS; i++) mask_q[i] <= lane_evt[i].hit;
			end else if (pop) begin
				mask_q <= rest;
			end
			if (pop) out_valid_q <= 1'b1;
			else if (evt.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NUM_INPUTS; i++) begin
				level_q[i] <= lane_evt[i].rising;
				act_q[i]   <= lane_evt[i].is_active;
			end
			stamp_q <= now_ms;
		end
		if (pop) begin
			out_idx_q    <= low_idx;
			out_rising_q <= |(lowest & level_q);
			out_active_q <= |(lowest & act_q);
			out_stamp_q  <= stamp_q;
			out_last_q   <= (rest == '0);
		end
	end

	assign evt.valid     = out_valid_q;
	assign evt.bit_index = out_idx_q;
	assign evt.rising    = out_rising_q;
	assign evt.is_active = out_active_q;
	assign evt.stamp_ms  = out_stamp_q;
	assign evt.last      = out_last_q;

endmodule

[design/multi_bit_debounce_edge_events_core.sv]
// channel  dir  payload                                       handshake
// samp     in   sample[31:0] now_ms[31:0]                      valid/ready
// evt      out  bit_index[4:0] rising is_active stamp_ms last   valid/ready
// cfg      in   cfg_index[1:0] cfg_wdata[31:0]                 cfg_we
//
// all lanes update in the cycle a sample is accepted; its events then leave
// one per cycle while the event output is not stalled, lowest input first;
// a sample with no events puts nothing on the event channel
// the next sample is taken as the last event of the previous one moves to the
// output register; a stalled output only holds the batch behind it
// reset clears config to defaults, all stable levels and all windows

module multi_bit_debounce_edge_events_core import mbde_pkg::*; #(
	parameter int NUM_INPUTS = NUM_INPUTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [MASK_W-1:0]     cfg_wdata,
	mbde_sample_if.sink           samp,
	mbde_event_if.source          evt
);

	logic [MASK_W-1:0]     input_mask_q;
	logic [DEBOUNCE_W-1:0] debounce_ms_q;
	logic [MASK_W-1:0]     polarity_q;

	logic      take_ok;
	logic      accept;
	lane_evt_t lane_evt [NUM_INPUTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mask_q  <= '0;
			debounce_ms_q <= DEBOUNCE_W'(20);
			polarity_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INPUT_MASK: input_mask_q  <= cfg_wdata;
				REG_DEBOUNCE:   debounce_ms_q <= cfg_wdata[DEBOUNCE_W-1:0];
				REG_POLARITY:   polarity_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign samp.ready = take_ok;
	assign accept     = samp.valid && take_ok;

	for (genvar n = 0; n < NUM_INPUTS; n++) begin : g_lane
		logic mon;
		logic alow;
		logic cur;
		// inputs past the mask width are never monitored
		if (n < MASK_W) begin : g_in
			assign mon  = input_mask_q[n];
			assign alow = polarity_q[n];
			assign cur  = samp.sample[n];
		end else begin : g_out
			assign mon  = 1'b0;
			assign alow = 1'b0;
			assign cur  = 1'b0;
		end

		mbde_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.accept      (accept),
			.monitored   (mon),
			.low_true    (alow),
			.debounce_ms (debounce_ms_q),
			.cur         (cur),
			.now_ms      (samp.now_ms),
			.evt         (lane_evt[n])
		);
	end

	mbde_merge #(.NUM_INPUTS(NUM_INPUTS)) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.lane_evt (lane_evt),
		.now_ms   (samp.now_ms),
		.take_ok  (take_ok),
		.evt      (evt)
	);

endmodule
